// ===== rtl/bal_pkg.sv =====
// Package for the bounded array list: command and status codes, cell shift kinds.
// Field widths of the stream payloads. No dependencies.
package bal_pkg;

    localparam int unsigned CMD_W    = 3;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned CNT_W    = 5;
    localparam int unsigned STAT_W   = 2;
    localparam int unsigned IN_BITS  = CMD_W + IDX_W + WORD_W;
    localparam int unsigned OUT_BITS = WORD_W + CNT_W + STAT_W;
    localparam int unsigned IN_TW    = ((IN_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_TW   = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ_AT    = 3'd0,
        CMD_INSERT_AT  = 3'd1,
        CMD_REMOVE_AT  = 3'd2,
        CMD_PUSH_BACK  = 3'd3,
        CMD_PUSH_FRONT = 3'd4,
        CMD_POP_BACK   = 3'd5,
        CMD_POP_FRONT  = 3'd6,
        CMD_CLEAR      = 3'd7
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADIDX = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_OPEN,
        SH_CLOSE
    } t_shift;

endpackage

// ===== rtl/bal_cell.sv =====
// One storage cell of the list: holds a word, loads new data or takes a neighbor's word.
// Uses bal_pkg for the shift kind.
module bal_cell
    import bal_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned CW         = 5,
    parameter int unsigned POS        = 0
) (
    input  logic                  i_clk,
    input  t_shift                i_kind,
    input  logic [CW-1:0]         i_pos,
    input  logic [CW-1:0]         i_cnt,
    input  logic [DATA_WIDTH-1:0] i_din,
    input  logic [DATA_WIDTH-1:0] i_lo,
    input  logic [DATA_WIDTH-1:0] i_hi,
    output logic [DATA_WIDTH-1:0] o_data
);

    localparam logic [CW:0] MY_POS = (CW+1)'(POS);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic [CW:0]           w_pos;
    logic [CW:0]           w_cnt;

    assign w_pos = {1'b0, i_pos};
    assign w_cnt = {1'b0, i_cnt};

    always_comb begin
        n_data = r_data;
        case (i_kind)
            SH_OPEN: begin
                if (MY_POS == w_pos) begin
                    n_data = i_din;
                end else if (MY_POS > w_pos && MY_POS <= w_cnt) begin
                    n_data = i_lo;
                end
            end
            SH_CLOSE: begin
                if (MY_POS >= w_pos && (MY_POS + 1'b1) < w_cnt) begin
                    n_data = i_hi;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== rtl/bounded_array_list.sv =====
// Top level of the bounded array list: command decode, count register, result register.
// Instantiates a row of bal_cell; uses bal_pkg.
//
//  channel | dir | tdata fields (low bit up)               | tlast | tuser
//  s_axis  | in  | command[2:0] index[6:3] data_in[38:7]    |  --   |  --
//  m_axis  | out | data_out[31:0] count[36:32] status[38:37]|  --   |  --
//
// Cells at and above the command's position shift in parallel by one position.
// Reads go through a DEPTH-to-one select over the cells.
// Synchronous active-low reset empties the list; cell contents are not cleared.
// One result register: a new transaction is taken when it is empty or its result is taken the same cycle.
module bounded_array_list
    import bal_pkg::*;
#(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_TW-1:0]  s_axis_tdata,   // command, index, data_in
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_TW-1:0] m_axis_tdata    // data_out, count, status
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned XW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_out_valid;
    logic [WORD_W-1:0]     r_out_data;
    logic [CNT_W-1:0]      r_out_count;
    t_status               r_out_status;

    logic                  w_accept;
    t_cmd                  w_cmd;
    logic [IDX_W-1:0]      w_idx;
    logic [DATA_WIDTH-1:0] w_din;
    logic [XW-1:0]         w_idx_x;
    logic [XW-1:0]         w_cnt_x;
    t_shift                w_kind;
    logic [CW-1:0]         w_pos;
    logic [AW-1:0]         w_rd_addr;
    logic [DATA_WIDTH-1:0] w_rd_data;
    logic                  w_rd_use;
    t_status               w_status;
    logic [DATA_WIDTH-1:0] w_cell_q [DEPTH];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_cmd   = t_cmd'(s_axis_tdata[CMD_W-1:0]);
    assign w_idx   = s_axis_tdata[CMD_W +: IDX_W];
    assign w_din   = DATA_WIDTH'(s_axis_tdata[CMD_W + IDX_W +: WORD_W]);
    assign w_idx_x = XW'(w_idx);
    assign w_cnt_x = XW'(r_count);

    assign w_rd_data = w_cell_q[w_rd_addr];

    always_comb begin
        n_count   = r_count;
        w_kind    = SH_NONE;
        w_pos     = '0;
        w_rd_addr = '0;
        w_rd_use  = 1'b0;
        w_status  = ST_OK;
        case (w_cmd)
            CMD_READ_AT: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else if (w_idx_x >= w_cnt_x) begin
                    w_status = ST_BADIDX;
                end else begin
                    w_rd_addr = AW'(w_idx_x);
                    w_rd_use  = 1'b1;
                end
            end
            CMD_INSERT_AT: begin
                if (r_count == FULL_CNT) begin
                    w_status = ST_FULL;
                end else if (w_idx_x > w_cnt_x) begin
                    w_status = ST_BADIDX;
                end else begin
                    w_kind  = SH_OPEN;
                    w_pos   = CW'(w_idx_x);
                    n_count = r_count + 1'b1;
                end
            end
            CMD_REMOVE_AT: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else if (w_idx_x >= w_cnt_x) begin
                    w_status = ST_BADIDX;
                end else begin
                    w_kind  = SH_CLOSE;
                    w_pos   = CW'(w_idx_x);
                    n_count = r_count - 1'b1;
                end
            end
            CMD_PUSH_BACK: begin
                if (r_count == FULL_CNT) begin
                    w_status = ST_FULL;
                end else begin
                    w_kind  = SH_OPEN;
                    w_pos   = r_count;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_PUSH_FRONT: begin
                if (r_count == FULL_CNT) begin
                    w_status = ST_FULL;
                end else begin
                    w_kind  = SH_OPEN;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_count   = r_count - 1'b1;
                    w_rd_addr = AW'(n_count);
                    w_rd_use  = 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_kind   = SH_CLOSE;
                    w_rd_use = 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
        if (!w_accept) begin
            w_kind  = SH_NONE;
            n_count = r_count;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_lo;
        logic [DATA_WIDTH-1:0] w_hi;
        if (g == 0) begin : g_lo_edge
            assign w_lo = '0;
        end else begin : g_lo_link
            assign w_lo = w_cell_q[g-1];
        end
        if (g == DEPTH - 1) begin : g_hi_edge
            assign w_hi = '0;
        end else begin : g_hi_link
            assign w_hi = w_cell_q[g+1];
        end
        bal_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CW         (CW),
            .POS        (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_kind (w_kind),
            .i_pos  (w_pos),
            .i_cnt  (r_count),
            .i_din  (w_din),
            .i_lo   (w_lo),
            .i_hi   (w_hi),
            .o_data (w_cell_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data   <= w_rd_use ? WORD_W'(w_rd_data) : '0;
            r_out_count  <= CNT_W'(n_count);
            r_out_status <= w_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TW'({r_out_status, r_out_count, r_out_data});

endmodule
